>>> src/radix_text_to_integer_defines.svh
// assertion macros for the radix text to integer parser
// used by the top level; no other dependencies
`ifndef RADIX_TEXT_TO_INTEGER_DEFINES_SVH
`define RADIX_TEXT_TO_INTEGER_DEFINES_SVH

`ifndef SYNTHESIS

`define RTTI_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define RTTI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define RTTI_ASSERT_SAME(label, clk, rstn, ante, cons)

`define RTTI_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> src/rtti_pkg.sv
// shared types, character codes and helpers for the radix text to integer parser
// no dependencies
package rtti_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DIGIT_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LEN_W      = 5;
    localparam int VALUE_W    = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_BASE_LEN   = 2'd2;

    typedef enum logic [1:0] {
        PH_DONE  = 2'd0,
        PH_SPACE = 2'd1,
        PH_SIGN  = 2'd2,
        PH_DIGIT = 2'd3
    } phase_t;

    typedef struct packed {
        logic               base_invalid;
        logic               hit;
        logic [DIGIT_W-1:0] digit;
    } alpha_match_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

>>> src/rtti_alpha_match.sv
// alphabet unit: base validity check and digit position lookup
// depends on rtti_pkg
module rtti_alpha_match
    import rtti_pkg::*;
(
    input  logic [63:0]      alphabet_low,
    input  logic [63:0]      alphabet_high,
    input  logic [LEN_W-1:0] base_length,
    input  logic [7:0]       ch,
    output alpha_match_t     match
);

    logic [127:0]     alpha_all;
    logic [7:0]       chars [MAX_DIGITS];
    logic [LEN_W-1:0] n_eff;
    logic             bad;

    assign alpha_all = {alphabet_high, alphabet_low};
    assign n_eff = (base_length > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : base_length;

    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            chars[k] = alpha_all[8*k +: 8];
        end
    end

    // out-of-range length, bad characters and duplicates among the characters in use
    always_comb begin
        bad = (base_length <= LEN_W'(1)) || (base_length > LEN_W'(MAX_DIGITS));
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (LEN_W'(i) < n_eff) begin
                if (chars[i] == CH_NUL || is_blank(chars[i]) ||
                    chars[i] == CH_PLUS || chars[i] == CH_MINUS) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_DIGITS; j++) begin
                    if (LEN_W'(j) < n_eff && chars[j] == chars[i]) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    // lowest matching position wins
    always_comb begin
        match.base_invalid = bad;
        match.hit          = 1'b0;
        match.digit        = '0;
        for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
            if (LEN_W'(k) < n_eff && chars[k] == ch) begin
                match.hit   = 1'b1;
                match.digit = DIGIT_W'(k);
            end
        end
    end

endmodule

>>> src/radix_text_to_integer.sv
// radix text to integer parser, top level: config registers, byte stream, result stream
// depends on rtti_pkg, rtti_alpha_match and radix_text_to_integer_defines.svh
//
// Takes one text byte per clock while results are taken (a held result stalls the
// input) and parses a signed integer whose digit alphabet (up to 16 characters)
// and radix are set through the register port. A byte with tuser set starts a new
// string; leading blanks are skipped, a run of '+'/'-' sets the sign, alphabet
// characters are digits, and the first other byte ends the number and emits one
// 32-bit wrapped result. An invalid alphabet gives 0 with the flag set on the start
// byte. The result of a terminating byte passes through the input register, then
// the result register. The per-byte path is one 16-way alphabet compare and a 32x5
// multiply-add on the accumulator. No clearing pass after reset.
`include "radix_text_to_integer_defines.svh"

module radix_text_to_integer
    import rtti_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] ch
    input  logic                s_tuser,   // [0] start_req

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,   // [31:0] value
    output logic                m_tuser    // [0] base_invalid
);

    logic [63:0]        alpha_low_reg;
    logic [63:0]        alpha_high_reg;
    logic [LEN_W-1:0]   base_len_reg;
    logic [1:0]         reg_idx;
    logic               cfg_write;

    logic               in_valid_reg;
    logic [7:0]         in_ch_reg;
    logic               in_start_reg;

    phase_t             phase_reg, phase_next, ph_eff;
    logic               neg_reg, neg_next, neg_eff;
    logic [VALUE_W-1:0] acc_reg, acc_next, acc_eff, acc_mul;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_inv_reg;

    logic               proc_fire;
    logic               emit;
    logic [VALUE_W-1:0] res_value;
    logic               res_inv;
    alpha_match_t       lk;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_len_reg   <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                REG_BASE_LEN:   base_len_reg   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            REG_BASE_LEN:   prdata = {{(64-LEN_W){1'b0}}, base_len_reg};
            default:        prdata = '0;
        endcase
    end

    // input register
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg    <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    rtti_alpha_match u_match (
        .alphabet_low  (alpha_low_reg),
        .alphabet_high (alpha_high_reg),
        .base_length   (base_len_reg),
        .ch            (in_ch_reg),
        .match         (lk)
    );

    // parse step
    assign acc_mul = VALUE_W'(acc_eff * VALUE_W'(base_len_reg));

    always_comb begin
        ph_eff  = phase_reg;
        neg_eff = neg_reg;
        acc_eff = acc_reg;
        if (in_start_reg) begin
            neg_eff = 1'b0;
            acc_eff = '0;
            ph_eff  = lk.base_invalid ? PH_DONE : PH_SPACE;
        end

        phase_next = ph_eff;
        neg_next   = neg_eff;
        acc_next   = acc_eff;
        emit       = 1'b0;
        res_value  = '0;
        res_inv    = 1'b0;

        priority if (in_start_reg && lk.base_invalid) begin
            emit    = 1'b1;
            res_inv = 1'b1;
        end else if (ph_eff == PH_DONE) begin
        end else if (ph_eff == PH_SPACE && is_blank(in_ch_reg)) begin
        end else if ((ph_eff == PH_SPACE || ph_eff == PH_SIGN) &&
                     (in_ch_reg == CH_PLUS || in_ch_reg == CH_MINUS)) begin
            if (in_ch_reg == CH_MINUS) begin
                neg_next = !neg_eff;
            end
            phase_next = PH_SIGN;
        end else if (!lk.hit) begin
            emit       = 1'b1;
            res_value  = neg_eff ? (VALUE_W'(0) - acc_eff) : acc_eff;
            phase_next = PH_DONE;
        end else begin
            acc_next   = acc_mul + VALUE_W'(lk.digit);
            phase_next = PH_DIGIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            out_value_reg <= res_value;
            out_inv_reg   <= res_inv;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_inv_reg;

    `RTTI_ASSERT_SAME(a_invalid_gives_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `RTTI_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready)
    `RTTI_ASSERT_NEXT(a_emit_ends_parse, aclk, aresetn, proc_fire && emit,
        phase_reg == PH_DONE && m_tvalid)
    `RTTI_ASSERT_NEXT(a_bad_base_flagged, aclk, aresetn,
        proc_fire && in_start_reg && lk.base_invalid, m_tvalid && m_tuser)

endmodule

>>> dv/tb_radix_text_to_integer.sv
// testbench for radix_text_to_integer: directed and random text streams with a
// cycle-free predictor, random idling on both stream sides and register reloads
// depends on rtti_pkg and the radix_text_to_integer rtl
module tb_radix_text_to_integer;
    import rtti_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               invalid;
    } parse_result_t;

    localparam logic [127:0] HEX_DIGITS = "fedcba9876543210";
    localparam logic [127:0] DEC_DIGITS = "9876543210";

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;   // [7:0] ch
    logic               s_tuser = 1'b0; // [0] start_req
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;        // [31:0] value
    logic               m_tuser;        // [0] base_invalid

    // predictor state and register copies
    logic [63:0]        alpha_lo_q = '0;
    logic [63:0]        alpha_hi_q = '0;
    logic [LEN_W-1:0]   radix_q = '0;
    phase_t             parse_phase = PH_DONE;
    logic               neg_q = 1'b0;
    logic [31:0]        acc_q = '0;

    parse_result_t      expected_numbers[$];
    int                 mismatch_count = 0;
    int                 sent_bytes = 0;
    int                 src_idle_pct = 0;
    int                 rx_stall_pct = 0;
    logic               hold_rx = 1'b0;

    radix_text_to_integer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("tb_radix_text_to_integer: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_numbers.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %0d flag %0b",
                         $time, $signed(m_tdata), m_tuser);
                mismatch_count++;
            end else begin
                want = expected_numbers.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, $signed(want.value), $signed(m_tdata));
                    mismatch_count++;
                end
                if (m_tuser !== want.invalid) begin
                    $display("%0t: base_invalid mismatch, expected %0b, got %0b",
                             $time, want.invalid, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic [7:0] alpha_char(input int k);
        logic [63:0] word;
        word = (k < 8) ? alpha_lo_q : alpha_hi_q;
        return word[8*(k%8) +: 8];
    endfunction

    function automatic bit is_white(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit digit_allowed(input logic [7:0] c);
        return c != CH_NUL && !is_white(c) && c != CH_PLUS && c != CH_MINUS;
    endfunction

    function automatic bit radix_bad();
        int i;
        int j;
        if (radix_q <= 1 || radix_q > MAX_DIGITS)
            return 1'b1;
        for (i = 0; i < radix_q; i++) begin
            if (!digit_allowed(alpha_char(i)))
                return 1'b1;
            for (j = i + 1; j < radix_q; j++)
                if (alpha_char(j) == alpha_char(i))
                    return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int digit_pos(input logic [7:0] c);
        int n;
        int k;
        n = (radix_q > MAX_DIGITS) ? MAX_DIGITS : radix_q;
        for (k = 0; k < n; k++)
            if (alpha_char(k) == c)
                return k;
        return -1;
    endfunction

    task automatic parse_text_byte(input logic [7:0] c, input logic start);
        int d;
        parse_result_t r;
        if (start) begin
            neg_q = 1'b0;
            acc_q = '0;
            if (radix_bad()) begin
                parse_phase = PH_DONE;
                r.value = '0;
                r.invalid = 1'b1;
                expected_numbers.push_back(r);
                return;
            end
            parse_phase = PH_SPACE;
        end
        if (parse_phase == PH_DONE)
            return;
        if (parse_phase == PH_SPACE && is_white(c))
            return;
        if ((parse_phase == PH_SPACE || parse_phase == PH_SIGN) &&
            (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS)
                neg_q = !neg_q;
            parse_phase = PH_SIGN;
            return;
        end
        d = digit_pos(c);
        if (d < 0) begin
            r.value = neg_q ? (32'd0 - acc_q) : acc_q;
            r.invalid = 1'b0;
            expected_numbers.push_back(r);
            parse_phase = PH_DONE;
            return;
        end
        acc_q = acc_q * radix_q + d;
        parse_phase = PH_DIGIT;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic start);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
        parse_text_byte(c, start);
    endtask

    // sender pauses until all results are back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_numbers.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ALPHA_LOW:  alpha_lo_q = data;
            REG_ALPHA_HIGH: alpha_hi_q = data;
            REG_BASE_LEN:   radix_q = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_base(input logic [127:0] chars, input int len);
        write_reg(REG_ALPHA_LOW, chars[63:0]);
        write_reg(REG_ALPHA_HIGH, chars[127:64]);
        write_reg(REG_BASE_LEN, 64'(len));
    endtask

    // distinct legal digits in the low len bytes, random filler above
    function automatic logic [127:0] make_alphabet(input int len);
        logic [127:0] chars;
        logic [7:0]   c;
        bit           dup;
        int           i;
        int           j;
        for (i = 0; i < 16; i++)
            chars[8*i +: 8] = 8'($urandom_range(0, 255));
        for (i = 0; i < len; i++) begin
            do begin
                c = 8'($urandom_range(0, 255));
                dup = 1'b0;
                for (j = 0; j < i; j++)
                    if (chars[8*j +: 8] == c)
                        dup = 1'b1;
            end while (dup || !digit_allowed(c));
            chars[8*i +: 8] = c;
        end
        return chars;
    endfunction

    function automatic int pick_radix();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 2;
        if (roll < 4)
            return MAX_DIGITS;
        return $urandom_range(2, MAX_DIGITS);
    endfunction

    // bad byte, duplicate, or too short
    task automatic load_bad_base(input int kind);
        logic [7:0]   bad_chars[9];
        logic [127:0] chars;
        int           len;
        int           i;
        int           j;
        bad_chars = '{CH_NUL, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE, CH_PLUS, CH_MINUS};
        len = pick_radix();
        chars = make_alphabet(len);
        if (kind < 9) begin
            chars[8*$urandom_range(0, len-1) +: 8] = bad_chars[kind];
        end else if (kind == 9) begin
            i = $urandom_range(0, len-2);
            j = $urandom_range(i+1, len-1);
            chars[8*j +: 8] = chars[8*i +: 8];
        end else begin
            len = $urandom_range(0, 1);
        end
        load_base(chars, len);
    endtask

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
            return CH_NUL;
        do c = 8'($urandom_range(0, 255)); while (digit_pos(c) >= 0);
        return c;
    endfunction

    task automatic send_random_string();
        logic [8:0] text[$];
        int         n;
        int         i;
        logic [7:0] c;
        if ($urandom_range(0, 99) < 75 && !radix_bad()) begin
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                c = 8'($urandom_range(9, 14));
                text.push_back({1'b0, (c == 8'd14) ? CH_SPACE : c});
            end
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                text.push_back({1'b0, $urandom_range(0, 1) ? CH_MINUS : CH_PLUS});
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                text.push_back({1'b0, alpha_char($urandom_range(0, radix_q - 1))});
            if ($urandom_range(0, 9) != 0 || text.size() == 0)
                text.push_back({1'b0, pick_terminator()});
            text[0][8] = 1'b1;
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                text.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                text.push_back({1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255))});
        end
        foreach (text[k])
            send_byte(text[k][7:0], text[k][8]);
    endtask

    task automatic test_reset_base();
        send_byte("x", 1'b1);
        send_byte("1", 1'b0);
        settle();
    endtask

    task automatic test_directed_hex();
        load_base(HEX_DIGITS, 16);
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte(CH_PLUS, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte("7", 1'b0);
        send_byte("f", 1'b0);
        send_byte(CH_NUL, 1'b0);
        // no digits at all
        send_byte(CH_PLUS, 1'b1);
        send_byte("z", 1'b0);
        // wraps past 32 bits
        send_byte("f", 1'b1);
        repeat (8) send_byte("f", 1'b0);
        send_byte(8'hFF, 1'b0);
        // restart abandons the open parse
        send_byte("1", 1'b1);
        send_byte("2", 1'b0);
        send_byte("3", 1'b1);
        send_byte(".", 1'b0);
        // ignored while done
        send_byte(CH_SPACE, 1'b0);
        send_byte("5", 1'b0);
        settle();
    endtask

    task automatic test_invalid_bases();
        for (int kind = 0; kind < 11; kind++) begin
            load_bad_base(kind);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_byte("0", 1'b0);
            settle();
        end
    endtask

    task automatic test_mid_string_change();
        load_base(HEX_DIGITS, 16);
        send_byte("1", 1'b1);
        send_byte("2", 1'b0);
        settle();
        load_base(DEC_DIGITS, 10);
        send_byte("3", 1'b0);
        send_byte("4", 1'b0);
        send_byte("a", 1'b0);
        settle();
        load_base(make_alphabet(2), 2);
        send_byte(alpha_char(1), 1'b1);
        send_byte(alpha_char(0), 1'b0);
        settle();
        load_base(make_alphabet(MAX_DIGITS), MAX_DIGITS);
        send_byte(alpha_char(15), 1'b0);
        send_byte(pick_terminator(), 1'b0);
        settle();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        rx_stall_pct = 0;
        load_base(DEC_DIGITS, 10);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (150) @(posedge aclk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (40) begin
            send_byte(8'("0" + $urandom_range(0, 9)), 1'b1);
            send_byte(";", 1'b0);
        end
        settle();
        repeat (10) send_random_string();
        settle();
    endtask

    task automatic test_random_stream(input int src_pct, input int rx_pct, input int count);
        int first;
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
        first = sent_bytes;
        while (sent_bytes - first < count) begin
            if ($urandom_range(0, 11) == 0) begin
                settle();
                if ($urandom_range(0, 99) < 85)
                    begin : reload_good
                        int len;
                        len = pick_radix();
                        load_base(make_alphabet(len), len);
                    end
                else
                    load_bad_base($urandom_range(0, 10));
            end
            send_random_string();
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_base();
        test_directed_hex();
        test_invalid_bases();
        test_mid_string_change();
        test_backpressure();
        test_random_stream(0, 0, 375);
        test_random_stream(77, 0, 375);
        test_random_stream(0, 77, 375);
        test_random_stream(33, 33, 375);
        repeat (8) @(posedge aclk);
        if (expected_numbers.size() != 0) begin
            $display("%0t: %0d results never arrived, expected none left, got %0d",
                     $time, expected_numbers.size(), expected_numbers.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_radix_text_to_integer: done, clean");
        else
            $display("tb_radix_text_to_integer: done, errors");
        $finish;
    end

endmodule
